FILE: design/assert_macros.svh
// shared assertion macros for the pulse channel
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define PCS_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent in this cycle implies consequent in the same cycle
`define PCS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: design/pcs_pkg.sv
package pcs_pkg;

    localparam int PCS_CFG_IDX_W  = 4;
    localparam int PCS_CFG_DATA_W = 8;

    localparam logic [7:0]  DIV_MASK_DMG  = 8'h1F;
    localparam logic [7:0]  DIV_MASK_CGB  = 8'h3F;
    localparam logic [11:0] PERIOD_SPAN   = 12'h800;
    localparam logic [6:0]  LENGTH_OFF    = 7'd64;
    localparam logic [1:0]  DUTY_RESET    = 2'd2;

    typedef enum logic {
        MODE_TICK = 1'b0,
        MODE_LOAD = 1'b1
    } t_pcs_mode;

    typedef enum logic [PCS_CFG_IDX_W-1:0] {
        CFG_CGB_MODE      = 4'd0,
        CFG_DUTY_SELECT   = 4'd1,
        CFG_ENVELOPE_PACE = 4'd2,
        CFG_ENVELOPE_UP   = 4'd3,
        CFG_LENGTH_RUN    = 4'd4,
        CFG_SWEEP_PACE    = 4'd5,
        CFG_SWEEP_DOWN    = 4'd6,
        CFG_SWEEP_SHIFT   = 4'd7
    } t_pcs_cfg_idx;

    typedef struct packed {
        t_pcs_mode   mode;
        logic [7:0]  div_value;
        logic [10:0] load_period;
        logic [3:0]  load_volume;
        logic [5:0]  load_length;
    } t_pcs_in;

    typedef struct packed {
        logic signed [14:0] sample;
        logic               channel_on;
        logic [10:0]        period_now;
        logic [2:0]         duty_step;
    } t_pcs_out;

    typedef struct packed {
        logic       cgb_mode;
        logic [1:0] duty_select;
        logic [2:0] envelope_pace;
        logic       envelope_up;
        logic       length_run;
        logic [2:0] sweep_pace;
        logic       sweep_down;
        logic [2:0] sweep_shift;
    } t_pcs_cfg;

    // trunc(volume * 8192 / 15)
    function automatic logic [13:0] vol_mag(input logic [3:0] vol);
        logic [13:0] m;
        case (vol)
            4'd0:    m = 14'd0;
            4'd1:    m = 14'd546;
            4'd2:    m = 14'd1092;
            4'd3:    m = 14'd1638;
            4'd4:    m = 14'd2184;
            4'd5:    m = 14'd2730;
            4'd6:    m = 14'd3276;
            4'd7:    m = 14'd3822;
            4'd8:    m = 14'd4369;
            4'd9:    m = 14'd4915;
            4'd10:   m = 14'd5461;
            4'd11:   m = 14'd6007;
            4'd12:   m = 14'd6553;
            4'd13:   m = 14'd7099;
            4'd14:   m = 14'd7645;
            default: m = 14'd8192;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] duty_mask(input logic [1:0] sel);
        logic [7:0] m;
        case (sel)
            2'd0:    m = 8'h80;
            2'd1:    m = 8'h81;
            2'd2:    m = 8'hE1;
            default: m = 8'h7E;
        endcase
        return m;
    endfunction

    // (2048 - period) * 4, modulo 8192
    function automatic logic [12:0] timer_reload(input logic [10:0] period);
        logic [11:0] diff;
        diff = PERIOD_SPAN - {1'b0, period};
        return {diff[10:0], 2'b00};
    endfunction

endpackage

FILE: design/pcs_cfg_regs.sv
module pcs_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pcs_pkg::PCS_CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pcs_pkg::PCS_CFG_DATA_W-1:0] i_cfg_data,
    output pcs_pkg::t_pcs_cfg                   o_cfg
);
    import pcs_pkg::*;

    t_pcs_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{duty_select: DUTY_RESET, default: '0};
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CGB_MODE:      r_cfg.cgb_mode      <= i_cfg_data[0];
                CFG_DUTY_SELECT:   r_cfg.duty_select   <= i_cfg_data[1:0];
                CFG_ENVELOPE_PACE: r_cfg.envelope_pace <= i_cfg_data[2:0];
                CFG_ENVELOPE_UP:   r_cfg.envelope_up   <= i_cfg_data[0];
                CFG_LENGTH_RUN:    r_cfg.length_run    <= i_cfg_data[0];
                CFG_SWEEP_PACE:    r_cfg.sweep_pace    <= i_cfg_data[2:0];
                CFG_SWEEP_DOWN:    r_cfg.sweep_down    <= i_cfg_data[0];
                CFG_SWEEP_SHIFT:   r_cfg.sweep_shift   <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

endmodule

FILE: design/pcs_core.sv
`include "assert_macros.svh"

module pcs_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pcs_pkg::t_pcs_cfg i_cfg,
    input  logic              i_step,
    input  pcs_pkg::t_pcs_in  i_item,
    output pcs_pkg::t_pcs_out o_result
);
    import pcs_pkg::*;

    logic [7:0]  r_last_div,  n_last_div;
    logic [2:0]  r_frame_step, n_frame_step;
    logic [10:0] r_period,    n_period;
    logic [3:0]  r_volume,    n_volume;
    logic [6:0]  r_length,    n_length;
    logic [2:0]  r_env_cnt,   n_env_cnt;
    logic [2:0]  r_sweep_cnt, n_sweep_cnt;
    logic [12:0] r_timer,     n_timer;
    logic [2:0]  r_duty_pos,  n_duty_pos;

    logic        frame_event;
    logic        run_done;
    logic [7:0]  low_mask;
    logic [10:0] sweep_delta;
    logic [11:0] sweep_next;
    logic [14:0] mag_ext;
    logic [7:0]  mask_bits;

    always_comb begin
        n_last_div   = r_last_div;
        n_frame_step = r_frame_step;
        n_period     = r_period;
        n_volume     = r_volume;
        n_length     = r_length;
        n_env_cnt    = r_env_cnt;
        n_sweep_cnt  = r_sweep_cnt;
        n_timer      = r_timer;
        n_duty_pos   = r_duty_pos;
        frame_event  = 1'b0;
        run_done     = 1'b0;
        low_mask     = i_cfg.cgb_mode ? DIV_MASK_CGB : DIV_MASK_DMG;
        sweep_delta  = r_period >> i_cfg.sweep_shift;
        sweep_next   = i_cfg.sweep_down ? ({1'b0, r_period} - {1'b0, sweep_delta})
                                        : ({1'b0, r_period} + {1'b0, sweep_delta});

        if (i_item.mode == MODE_LOAD) begin
            n_period    = i_item.load_period;
            n_volume    = i_item.load_volume;
            n_length    = {1'b0, i_item.load_length};
            n_env_cnt   = i_cfg.envelope_pace;
            n_sweep_cnt = i_cfg.sweep_pace;
            n_timer     = timer_reload(i_item.load_period);
        end else begin
            // frame sequencer follows the divider even while the channel is off
            if (i_item.div_value != r_last_div) begin
                n_last_div = i_item.div_value;
                if ((i_item.div_value & low_mask) == 8'd0) begin
                    n_frame_step = r_frame_step + 3'd1;
                    frame_event  = 1'b1;
                end
            end

            if (!r_length[6]) begin
                if (frame_event) begin
                    if (i_cfg.envelope_pace != 3'd0 && n_frame_step == 3'd0) begin
                        if (r_env_cnt == 3'd0) begin
                            if (i_cfg.envelope_up) begin
                                if (r_volume != 4'd15) n_volume = r_volume + 4'd1;
                            end else begin
                                if (r_volume != 4'd0) n_volume = r_volume - 4'd1;
                            end
                            n_env_cnt = i_cfg.envelope_pace;
                        end else begin
                            n_env_cnt = r_env_cnt - 3'd1;
                        end
                    end
                    if (i_cfg.length_run && !n_frame_step[0]) begin
                        n_length = r_length + 7'd1;
                        if (n_length[6]) begin
                            n_volume = 4'd0;
                            run_done = 1'b1;
                        end
                    end
                    if (!run_done && i_cfg.sweep_pace != 3'd0 && n_frame_step[1:0] == 2'd0) begin
                        if (r_sweep_cnt == 3'd0) begin
                            if (sweep_next[11]) begin
                                n_volume = 4'd0;
                                n_length = LENGTH_OFF;
                            end else begin
                                n_period = sweep_next[10:0];
                            end
                            n_sweep_cnt = i_cfg.sweep_pace;
                        end else begin
                            n_sweep_cnt = r_sweep_cnt - 3'd1;
                        end
                    end
                end
                if (!run_done) begin
                    n_timer = r_timer - 13'd1;
                    if (n_timer == 13'd0) begin
                        n_duty_pos = r_duty_pos + 3'd1;
                        n_timer    = timer_reload(n_period);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_div   <= '0;
            r_frame_step <= '0;
            r_period     <= '0;
            r_volume     <= '0;
            r_length     <= LENGTH_OFF;
            r_env_cnt    <= '0;
            r_sweep_cnt  <= '0;
            r_timer      <= '0;
            r_duty_pos   <= '0;
        end else if (i_step) begin
            r_last_div   <= n_last_div;
            r_frame_step <= n_frame_step;
            r_period     <= n_period;
            r_volume     <= n_volume;
            r_length     <= n_length;
            r_env_cnt    <= n_env_cnt;
            r_sweep_cnt  <= n_sweep_cnt;
            r_timer      <= n_timer;
            r_duty_pos   <= n_duty_pos;
        end
    end

    // result reflects the state after this item
    always_comb begin
        mag_ext   = {1'b0, vol_mag(n_volume)};
        mask_bits = duty_mask(i_cfg.duty_select);
        o_result.sample     = mask_bits[n_duty_pos] ? mag_ext : (15'd0 - mag_ext);
        o_result.channel_on = !n_length[6];
        o_result.period_now = n_period;
        o_result.duty_step  = n_duty_pos;
    end

    `PCS_ASSERT_ALWAYS(a_len_range, i_clk, i_rst_n, r_length <= LENGTH_OFF, "length count above 64")
    `PCS_ASSERT_IMPL(a_off_silent, i_clk, i_rst_n, r_length[6], r_volume == 4'd0, "volume while off")
    `PCS_ASSERT_IMPL(a_duty_step, i_clk, i_rst_n, $past(i_rst_n) && r_duty_pos != $past(r_duty_pos), r_duty_pos == $past(r_duty_pos) + 3'd1, "duty position skipped")

endmodule

FILE: design/pulse_channel_with_sweep_unit.sv
// an item waits in the input register until it advances, then its result is registered
// one item per cycle unless stalled, all channel state updates in one pass from input register
// a result not taken holds the result register, and a full input register stalls with it
// reset (synchronous, active low): channel off (length 64), all counters zero, duty select 2
module pulse_channel_with_sweep_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pcs_pkg::PCS_CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pcs_pkg::PCS_CFG_DATA_W-1:0] i_cfg_data,
    // tick or load items
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  pcs_pkg::t_pcs_in                    i_in,
    // one result per item
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output pcs_pkg::t_pcs_out                   o_out
);
    import pcs_pkg::*;

    t_pcs_cfg cfg;
    t_pcs_out core_result;

    // input register stage
    logic    r_in_valid;
    t_pcs_in r_in;

    // result register stage
    logic     r_out_valid;
    t_pcs_out r_out;

    // item moves from input register into result register, updating channel state
    logic advance;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    pcs_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    pcs_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_step   (advance),
        .i_item   (r_in),
        .o_result (core_result)
    );

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in;
        end
        if (advance) begin
            r_out <= core_result;
        end
    end

endmodule
